// ----- rtl/ccs_pkg.sv -----
// shared types, character constants and helpers for the comment stripper
package ccs_pkg;

  localparam logic [7:0] CHR_SLASH   = 8'h2F;
  localparam logic [7:0] CHR_STAR    = 8'h2A;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_VTAB    = 8'h0B;
  localparam logic [7:0] CHR_FFEED   = 8'h0C;
  localparam logic [7:0] CHR_CRET    = 8'h0D;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2
  } mode_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_item;
    logic       end_of_text;
  } result_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_NEWLINE) ||
            (c == CHR_VTAB) || (c == CHR_FFEED) || (c == CHR_CRET);
  endfunction

endpackage

// ----- rtl/ccs_step.sv -----
// per-byte comment stripping and whitespace collapsing with its state registers
module ccs_step
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output step_t      res
);

  mode_t mode, mode_next;
  logic  slash_pending, slash_pending_next;
  logic  star_seen, star_seen_next;
  logic  prev_was_space, prev_was_space_next;

  logic       ch0_v, ch1_v;
  logic [7:0] ch0, ch1;
  logic       e0_v, e1_v;
  logic [7:0] e0, e1;
  logic       pws_mid;

  // stage one: comment removal, up to two characters handed on
  always_comb begin
    mode_next          = mode;
    slash_pending_next = slash_pending;
    star_seen_next     = star_seen;
    ch0_v = 1'b0;
    ch0   = in_byte;
    ch1_v = 1'b0;
    ch1   = in_byte;
    unique case (mode)
      MODE_NORMAL: begin
        if (slash_pending) begin
          slash_pending_next = 1'b0;
          if (in_byte == CHR_SLASH) begin
            mode_next = MODE_LINE;
          end else if (in_byte == CHR_STAR) begin
            mode_next      = MODE_BLOCK;
            star_seen_next = 1'b0;
          end else begin
            ch0_v = 1'b1;
            ch0   = CHR_SLASH;
            ch1_v = 1'b1;
          end
        end else if (in_byte == CHR_SLASH) begin
          slash_pending_next = 1'b1;
        end else begin
          ch0_v = 1'b1;
        end
      end
      MODE_LINE: begin
        if (in_byte == CHR_NEWLINE) begin
          mode_next = MODE_NORMAL;
          ch0_v     = 1'b1;
        end
      end
      default: begin
        if (star_seen && in_byte == CHR_SLASH) begin
          mode_next      = MODE_NORMAL;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (in_byte == CHR_STAR);
        end
      end
    endcase
    // a slash held at the end of the text is flushed
    if (last_byte && slash_pending_next) begin
      slash_pending_next = 1'b0;
      ch0_v = 1'b1;
      ch0   = CHR_SLASH;
    end
  end

  // stage two: whitespace collapse, applied to both characters in order
  always_comb begin
    e0_v = 1'b0;
    e0   = ch0;
    pws_mid = prev_was_space;
    if (ch0_v) begin
      if (is_ws(ch0)) begin
        e0_v    = !prev_was_space;
        e0      = CHR_SPACE;
        pws_mid = 1'b1;
      end else begin
        e0_v    = 1'b1;
        pws_mid = 1'b0;
      end
    end
    e1_v = 1'b0;
    e1   = ch1;
    prev_was_space_next = pws_mid;
    if (ch1_v) begin
      if (is_ws(ch1)) begin
        e1_v                = !pws_mid;
        e1                  = CHR_SPACE;
        prev_was_space_next = 1'b1;
      end else begin
        e1_v                = 1'b1;
        prev_was_space_next = 1'b0;
      end
    end
  end

  // pack emitted characters into result items
  always_comb begin
    res = '0;
    priority if (e0_v && e1_v) begin
      res.count = 2'd2;
      res.r0    = '{out_byte: e0, byte_valid: 1'b1, last_of_item: 1'b0, end_of_text: 1'b0};
      res.r1    = '{out_byte: e1, byte_valid: 1'b1, last_of_item: 1'b1,
                    end_of_text: last_byte};
    end else if (e0_v || e1_v) begin
      res.count = 2'd1;
      res.r0    = '{out_byte: (e0_v ? e0 : e1), byte_valid: 1'b1, last_of_item: 1'b1,
                    end_of_text: last_byte};
    end else if (last_byte) begin
      // bare end marker
      res.count = 2'd1;
      res.r0    = '{out_byte: 8'h00, byte_valid: 1'b0, last_of_item: 1'b1,
                    end_of_text: 1'b1};
    end else begin
      res.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      slash_pending  <= 1'b0;
      star_seen      <= 1'b0;
      prev_was_space <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        mode           <= MODE_NORMAL;
        slash_pending  <= 1'b0;
        star_seen      <= 1'b0;
        prev_was_space <= 1'b0;
      end else begin
        mode           <= mode_next;
        slash_pending  <= slash_pending_next;
        star_seen      <= star_seen_next;
        prev_was_space <= prev_was_space_next;
      end
    end
  end

endmodule

// ----- rtl/ccs_outbuf.sv -----
// two-slot result register that drains one result item per transfer
module ccs_outbuf
  import ccs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  step_t   res,
  output logic    load_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic [1:0] cnt;
  result_t    slot0, slot1;
  logic       pop;

  assign pop        = (cnt != 2'd0) && out_ready;
  assign load_ready = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign out_valid  = (cnt != 2'd0);
  assign out_item   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res.r0;
      slot1 <= res.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result count out of range");
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == 2'd0) || ((cnt == 2'd1) && out_ready))
    else $error("load while results still pending");
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) && !out_ready |=> (cnt == 2'd2) && $stable(slot0))
    else $error("stalled pair changed");
  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !slot0.last_of_item && !slot0.end_of_text)
    else $error("first of two results marked last");
`endif

endmodule

// ----- rtl/comment_strip_space_collapse.sv -----
// top level: comment stripper followed by whitespace collapser on a byte stream
//
//   channel   dir  tdata        tuser                          tlast
//   s_axis    in   in_byte      -                              last_byte
//   m_axis    out  out_byte     byte_valid, last_of_item       end_of_text
//
// one input byte is taken per cycle unless the output stalls; it yields zero,
// one or two result items, and a byte that yields two holds the input while
// the two-slot result register drains. input ready follows output ready
// through that register. rst is synchronous and returns to normal text with
// no held slash. state also returns to reset after the byte marked last.
module comment_strip_space_collapse
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] last_of_item
  output logic       m_axis_tlast
);

  logic    accept;
  logic    load_ready;
  step_t   res;
  result_t out_item;

  assign s_axis_tready = load_ready;
  assign accept        = s_axis_tvalid && load_ready;

  ccs_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .res       (res)
  );

  ccs_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && (res.count != 2'd0)),
    .res        (res),
    .load_ready (load_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_item   (out_item)
  );

  assign m_axis_tdata = out_item.out_byte;
  assign m_axis_tuser = {out_item.last_of_item, out_item.byte_valid};
  assign m_axis_tlast = out_item.end_of_text;

endmodule

// ----- test/comment_strip_space_collapse_test.sv -----
// testbench for the comment stripper and whitespace collapser
`timescale 1ns / 100ps

module comment_strip_space_collapse_test;
  import ccs_pkg::*;

  // predicts the result stream from accepted text bytes and checks the output against it
  class text_scoreboard;
    mode_t      mode;
    bit         slash_held;
    bit         star_armed;
    bit         after_space;
    result_t    expected_q[$];
    logic [7:0] emit_buf[$];
    int         bytes_in;
    int         results_seen;
    int         errors;
    int         texts;
    int         empty_ends;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      mode        = MODE_NORMAL;
      slash_held  = 1'b0;
      star_armed  = 1'b0;
      after_space = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_NEWLINE) ||
             (c == CHR_VTAB) || (c == CHR_FFEED) || (c == CHR_CRET);
    endfunction

    // second stage: a whitespace run becomes one space
    function void collapse(logic [7:0] c);
      if (is_blank(c)) begin
        if (!after_space) begin
          emit_buf.insert(emit_buf.size(), CHR_SPACE);
          after_space = 1'b1;
        end
      end else begin
        emit_buf.insert(emit_buf.size(), c);
        after_space = 1'b0;
      end
    endfunction

    function void note_byte(logic [7:0] c, bit is_last);
      result_t r;
      emit_buf.delete();
      bytes_in++;
      case (mode)
        MODE_NORMAL: begin
          if (slash_held) begin
            slash_held = 1'b0;
            if (c == CHR_SLASH) begin
              mode = MODE_LINE;
            end else if (c == CHR_STAR) begin
              // the opening star never closes the comment
              mode = MODE_BLOCK;
              star_armed = 1'b0;
            end else begin
              collapse(CHR_SLASH);
              collapse(c);
            end
          end else if (c == CHR_SLASH) begin
            slash_held = 1'b1;
          end else begin
            collapse(c);
          end
        end
        MODE_LINE: begin
          if (c == CHR_NEWLINE) begin
            mode = MODE_NORMAL;
            collapse(c);
          end
        end
        default: begin
          if (star_armed && c == CHR_SLASH) begin
            mode = MODE_NORMAL;
            star_armed = 1'b0;
          end else begin
            star_armed = (c == CHR_STAR);
          end
        end
      endcase
      // a slash still held at end of text goes out last
      if (is_last && slash_held) begin
        slash_held = 1'b0;
        collapse(CHR_SLASH);
      end
      if (emit_buf.size() == 0) begin
        if (is_last) begin
          r.out_byte     = 8'h00;
          r.byte_valid   = 1'b0;
          r.last_of_item = 1'b1;
          r.end_of_text  = 1'b1;
          expected_q.insert(expected_q.size(), r);
          empty_ends++;
        end
      end else begin
        foreach (emit_buf[k]) begin
          r.out_byte     = emit_buf[k];
          r.byte_valid   = 1'b1;
          r.last_of_item = (k == emit_buf.size() - 1);
          r.end_of_text  = r.last_of_item && is_last;
          expected_q.insert(expected_q.size(), r);
        end
      end
      if (is_last) begin
        clear_state();
        texts++;
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] user, logic tl);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual byte %h user %b last %b",
                 $time, data, user, tl);
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.out_byte)
        report("out_byte", want.out_byte, data);
      if (user[0] !== want.byte_valid)
        report("byte_valid", 8'(want.byte_valid), 8'(user[0]));
      if (user[1] !== want.last_of_item)
        report("last_of_item", 8'(want.last_of_item), 8'(user[1]));
      if (tl !== want.end_of_text)
        report("end_of_text", 8'(want.end_of_text), 8'(tl));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic [1:0] m_axis_tuser;   // [0] byte_valid, [1] last_of_item
  logic       m_axis_tlast;

  text_scoreboard board;
  logic [7:0]     text_buf[$];
  int             calm_left[2];
  bit             calm[2];

  comment_strip_space_collapse dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // side 0 sends, side 1 receives; stretches of back-to-back traffic between busy ones
  function automatic int next_gap(input int side);
    if (calm_left[side] == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      calm[side]      = ($urandom_range(0, 3) == 0);
    end
    calm_left[side]--;
    return calm[side] ? 0 : $urandom_range(0, 12);
  endfunction

  // append one byte to the text being built
  function automatic void add_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CHR_SPACE;
      1:       return CHR_TAB;
      2:       return CHR_NEWLINE;
      3:       return CHR_VTAB;
      4:       return CHR_FFEED;
      default: return CHR_CRET;
    endcase
  endfunction

  function automatic logic [7:0] comment_byte();
    case ($urandom_range(0, 4))
      0:       return CHR_STAR;
      1:       return CHR_SLASH;
      2:       return pick_blank();
      3:       return 8'($urandom);
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    int gap;
    gap = next_gap(0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    board.note_byte(b, is_last);
  endtask

  task automatic send_text();
    foreach (text_buf[i])
      send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
    send_text();
  endtask

  // mostly well-formed comments and whitespace runs, with stray slashes and raw bytes mixed in
  task automatic build_random_text();
    int tokens;
    text_buf.delete();
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0: add_byte(8'($urandom));
        1, 2: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(33, 126)));
        3: repeat ($urandom_range(1, 3)) add_byte(pick_blank());
        4: begin
          add_byte(CHR_SLASH);
          add_byte(CHR_SLASH);
          repeat ($urandom_range(0, 5)) add_byte(comment_byte());
          if ($urandom_range(0, 5) != 0) add_byte(CHR_NEWLINE);
        end
        5, 6: begin
          add_byte(CHR_SLASH);
          add_byte(CHR_STAR);
          if ($urandom_range(0, 3) == 0) add_byte(CHR_SLASH);
          repeat ($urandom_range(0, 5)) add_byte(comment_byte());
          if ($urandom_range(0, 5) != 0) begin
            add_byte(CHR_STAR);
            add_byte(CHR_SLASH);
          end
        end
        7: begin
          add_byte(CHR_SLASH);
          add_byte(($urandom_range(0, 1) == 0) ? pick_blank() :
                   8'($urandom_range(33, 126)));
        end
        8: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(128, 255)));
        default: add_byte(CHR_SLASH);
      endcase
    end
  endtask

  initial begin
    board = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // held slash released, slash-star-slash staying open, line comment keeping its newline,
    // high bytes and collapsing, unterminated block, lone final slash, slash before blank
    send_string("a/b");
    send_string("/*/*/z");
    send_string("//\011\n");
    send_string("\200 \011\377/");
    send_string("/**");
    send_string("/");
    send_string(" /\013");

    while (board.bytes_in < 550) begin
      build_random_text();
      send_text();
    end
    s_axis_tvalid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d texts, %0d bytes sent, %0d results checked (%0d bare end markers)",
             board.texts, board.bytes_in, board.results_seen, board.empty_ends);
    $display("errors found: %0d", board.errors);
    if (board.errors == 0)
      $display("comment_strip_space_collapse: match");
    else
      $display("comment_strip_space_collapse: mismatch");
    $finish;
  end

  // output side: random stalls, one result per transfer
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = next_gap(1);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("comment_strip_space_collapse: mismatch");
    $finish;
  end

endmodule
